// File: sv/rgb_to_yuv420_converter_top_macros.svh
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_top_macros.svh
// Assertion macros for the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, held off during reset
`define RYUV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ryuv: same-cycle check failed");

// next-cycle implication, held off during reset
`define RYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ryuv: next-cycle check failed");

`else

`define RYUV_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RYUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/ryuv_pkg.sv
// ----------------------------------------------------------------------------
// ryuv_pkg
// Shared constants, types and color math for the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ryuv_pkg;

  // frame geometry
  localparam int MAX_WIDTH       = 2048;
  localparam int LINE_DEPTH      = MAX_WIDTH / 2;
  localparam int LINE_AW         = $clog2(LINE_DEPTH);
  localparam int HW_W            = 11;
  localparam int HH_W            = 12;
  localparam int ROW_W           = 12;
  localparam int PIX_W           = 8;
  localparam int SUM_W           = PIX_W + 1;
  localparam int LINE_DW         = 3 * SUM_W;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 12;

  // register reset values
  localparam logic [HW_W-1:0] HALF_WIDTH_RST  = HW_W'(400);
  localparam logic [HH_W-1:0] HALF_HEIGHT_RST = HH_W'(250);

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_HALF_WIDTH  = 2'd0;
  localparam cfg_index_t REG_HALF_HEIGHT = 2'd1;

  // one item between the control stage and the color stage
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;
    logic             chroma;
    logic             frame_end;
  } ryuv_s1_t;

  // line buffer write / read request
  typedef struct packed {
    logic               wr_en;
    logic [LINE_AW-1:0] wr_addr;
    logic [LINE_DW-1:0] wr_data;
    logic               rd_en;
    logic [LINE_AW-1:0] rd_addr;
  } ryuv_mem_req_t;

  // Y = ((66r + 129g + 25b + 128) >> 8) + 16, clamped
  function automatic logic [PIX_W-1:0] luma_fn(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [15:0] s;
    logic [8:0]  y;
    s = 16'd66 * {8'd0, r} + 16'd129 * {8'd0, g} + 16'd25 * {8'd0, b} + 16'd128;
    y = {1'b0, s[15:8]} + 9'd16;
    return (y > 9'd255) ? 8'd255 : y[7:0];
  endfunction

  // floor((v + 128) / 256) + 128, clamped to 0..255
  function automatic logic [PIX_W-1:0] chroma_fin(input logic signed [17:0] v);
    logic signed [17:0] t;
    logic [9:0]         q;
    t = v + 18'sd32896;
    q = t[17:8];
    if (t < 0) begin
      return 8'd0;
    end
    return (q > 10'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] cb_fn(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
    logic signed [17:0] v;
    v = -18'sd38 * $signed({10'd0, r}) - 18'sd74 * $signed({10'd0, g})
        + 18'sd112 * $signed({10'd0, b});
    return chroma_fin(v);
  endfunction

  function automatic logic [PIX_W-1:0] cr_fn(input logic [PIX_W-1:0] r,
                                             input logic [PIX_W-1:0] g,
                                             input logic [PIX_W-1:0] b);
    logic signed [17:0] v;
    v = 18'sd112 * $signed({10'd0, r}) - 18'sd94 * $signed({10'd0, g})
        - 18'sd18 * $signed({10'd0, b});
    return chroma_fin(v);
  endfunction

endpackage

`default_nettype wire

// File: sv/ryuv_line_ram.sv
// ----------------------------------------------------------------------------
// ryuv_line_ram
// Line buffer: per pixel pair, the channel sums of the upper row of a block.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ryuv_line_ram (
  input  wire                              clk,
  input  wire  ryuv_pkg::ryuv_mem_req_t    req,
  output logic [ryuv_pkg::LINE_DW-1:0]     rd_data_r
);
  import ryuv_pkg::*;

  logic [LINE_DW-1:0] mem [LINE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/ryuv_ctrl.sv
// ----------------------------------------------------------------------------
// ryuv_ctrl
// Input side: frame counters, pair hold, line buffer access and the first
// pipeline register (pixel plus 2x2 block averages).
// ----------------------------------------------------------------------------
`default_nettype none

module ryuv_ctrl (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [23:0]                         in_tdata,   // red, green, blue
  input  wire                                 adv,
  input  wire  [ryuv_pkg::HW_W-1:0]           half_width,
  input  wire  [ryuv_pkg::HH_W-1:0]           half_height,
  output ryuv_pkg::ryuv_mem_req_t             mem_req,
  input  wire  [ryuv_pkg::LINE_DW-1:0]        mem_rd_data,
  output ryuv_pkg::ryuv_s1_t                  s1_r,
  output logic                                col_odd_r
);
  import ryuv_pkg::*;

  logic                 acc;
  logic [PIX_W-1:0]     red, green, blue;
  logic [3*PIX_W-1:0]   hold_r;
  logic [LINE_AW-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic                 col_odd_nxt;
  logic [LINE_AW-1:0]   col_last;
  logic [HH_W-2:0]      hh_m1;
  logic [ROW_W-1:0]     row_last;
  logic                 fend;
  logic [SUM_W-1:0]     sum_r, sum_g, sum_b;
  logic [SUM_W:0]       tot_r, tot_g, tot_b;
  ryuv_s1_t             s1_nxt;

  assign red   = in_tdata[7:0];
  assign green = in_tdata[15:8];
  assign blue  = in_tdata[23:16];

  assign in_tready = !s1_r.valid || adv;
  assign acc       = in_tvalid && in_tready;

  // last pair index of a row, size clamped to 1..LINE_DEPTH
  always_comb begin
    if (half_width == '0) begin
      col_last = '0;
    end else if (32'(half_width) > 32'(LINE_DEPTH)) begin
      col_last = LINE_AW'(LINE_DEPTH - 1);
    end else begin
      col_last = LINE_AW'(half_width - HW_W'(1));
    end
  end

  // last row index: 2h-1 with h clamped to 1..2048
  always_comb begin
    if (half_height == '0) begin
      hh_m1 = '0;
    end else if (half_height > HH_W'(2048)) begin
      hh_m1 = '1;
    end else begin
      hh_m1 = (HH_W-1)'(half_height - HH_W'(1));
    end
  end
  assign row_last = {hh_m1, 1'b1};

  // pair sums and block sums
  assign sum_r = {1'b0, red}   + {1'b0, hold_r[7:0]};
  assign sum_g = {1'b0, green} + {1'b0, hold_r[15:8]};
  assign sum_b = {1'b0, blue}  + {1'b0, hold_r[23:16]};
  assign tot_r = {1'b0, sum_r} + {1'b0, mem_rd_data[SUM_W-1:0]};
  assign tot_g = {1'b0, sum_g} + {1'b0, mem_rd_data[2*SUM_W-1:SUM_W]};
  assign tot_b = {1'b0, sum_b} + {1'b0, mem_rd_data[3*SUM_W-1:2*SUM_W]};

  // line buffer: upper row writes on the right pixel, lower row reads on the left
  always_comb begin
    mem_req.wr_en   = acc && col_odd_r && !row_r[0];
    mem_req.wr_addr = col_r;
    mem_req.wr_data = {sum_b, sum_g, sum_r};
    mem_req.rd_en   = acc && !col_odd_r && row_r[0];
    mem_req.rd_addr = col_r;
  end

  // counters
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    col_odd_nxt = col_odd_r;
    fend        = 1'b0;
    if (acc) begin
      col_odd_nxt = !col_odd_r;
      if (col_odd_r) begin
        if (col_r >= col_last) begin
          col_nxt = '0;
          if (row_r >= row_last) begin
            row_nxt = '0;
            fend    = 1'b1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + LINE_AW'(1);
        end
      end
    end
  end

  // first pipeline register
  always_comb begin
    s1_nxt = s1_r;
    if (acc) begin
      s1_nxt.valid     = 1'b1;
      s1_nxt.red       = red;
      s1_nxt.green     = green;
      s1_nxt.blue      = blue;
      s1_nxt.avg_red   = tot_r[SUM_W:2];
      s1_nxt.avg_green = tot_g[SUM_W:2];
      s1_nxt.avg_blue  = tot_b[SUM_W:2];
      s1_nxt.chroma    = col_odd_r && row_r[0];
      s1_nxt.frame_end = fend;
    end else if (adv) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      col_odd_r   <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      col_odd_r   <= col_odd_nxt;
    end
  end

  // stage register: only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.red       <= s1_nxt.red;
    s1_r.green     <= s1_nxt.green;
    s1_r.blue      <= s1_nxt.blue;
    s1_r.avg_red   <= s1_nxt.avg_red;
    s1_r.avg_green <= s1_nxt.avg_green;
    s1_r.avg_blue  <= s1_nxt.avg_blue;
    s1_r.chroma    <= s1_nxt.chroma;
    s1_r.frame_end <= s1_nxt.frame_end;
  end

  // left pixel hold
  always_ff @(posedge clk) begin
    if (acc && !col_odd_r) begin
      hold_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

// File: sv/ryuv_color.sv
// ----------------------------------------------------------------------------
// ryuv_color
// Color math and output register: luma per pixel, Cb/Cr per closed block.
// ----------------------------------------------------------------------------
`default_nettype none

module ryuv_color (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire ryuv_pkg::ryuv_s1_t s1,
  output logic                   adv,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [23:0]            out_tdata,  // luma, chroma_blue, chroma_red
  output logic                   out_tuser,  // chroma_valid
  output logic                   out_tlast   // frame_end
);
  import ryuv_pkg::*;

  logic             out_v_r;
  logic [PIX_W-1:0] luma_r, cb_r, cr_r;
  logic             cv_r, fend_r;

  // output register free or being emptied
  assign adv = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && s1.valid) begin
      luma_r <= luma_fn(s1.red, s1.green, s1.blue);
      cb_r   <= s1.chroma ? cb_fn(s1.avg_red, s1.avg_green, s1.avg_blue) : '0;
      cr_r   <= s1.chroma ? cr_fn(s1.avg_red, s1.avg_green, s1.avg_blue) : '0;
      cv_r   <= s1.chroma;
      fend_r <= s1.frame_end;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {cr_r, cb_r, luma_r};
  assign out_tuser  = cv_r;
  assign out_tlast  = fend_r;

endmodule

`default_nettype wire

// File: sv/rgb_to_yuv420_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_top
// BT.601 RGB to YCbCr 4:2:0 converter, one pixel per clock unless held, raster order.
//
// in_*  : one RGB pixel per item, raster order, frame of 2*half_width by
//         2*half_height pixels.
// out_* : one item per pixel: luma, plus Cb/Cr with tuser high on the pixel
//         closing a 2x2 block (odd row, odd column); tlast on the frame's
//         last pixel.
// cfg_* : register writes (index 0 half_width, index 1 half_height); always
//         ready, write only while no item is in flight.
// Two register stages, s1_r then the output register; out_tvalid rises when an
// item reaches the latter. One item per cycle when not stalled by out_tready, at most
// one line access each. The lower row's line read is issued on the left pixel of a
// pair and used on the right one.
// Reset clears counters and pipeline, loads half_width 400 / half_height 250;
// the line buffer is not cleared. When out_tready is low the output register
// holds, one more item can still enter the stage ahead of it if that stage is empty,
// then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_yuv420_converter_top_macros.svh"

module rgb_to_yuv420_converter_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [23:0]                      in_tdata,   // red, green, blue
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [23:0]                      out_tdata,  // luma, chroma_blue, chroma_red
  output logic                             out_tuser,  // chroma_valid
  output logic                             out_tlast,  // frame_end
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ryuv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [ryuv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ryuv_pkg::*;

  logic [HW_W-1:0]    half_width_r, half_width_nxt;
  logic [HH_W-1:0]    half_height_r, half_height_nxt;
  logic               adv;
  logic               col_odd;
  ryuv_s1_t           s1;
  ryuv_mem_req_t      mem_req;
  logic [LINE_DW-1:0] mem_rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    half_width_nxt  = half_width_r;
    half_height_nxt = half_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALF_WIDTH:  half_width_nxt  = cfg_data[HW_W-1:0];
        REG_HALF_HEIGHT: half_height_nxt = cfg_data[HH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r  <= HALF_WIDTH_RST;
      half_height_r <= HALF_HEIGHT_RST;
    end else begin
      half_width_r  <= half_width_nxt;
      half_height_r <= half_height_nxt;
    end
  end

  ryuv_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .adv         (adv),
    .half_width  (half_width_r),
    .half_height (half_height_r),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .s1_r        (s1),
    .col_odd_r   (col_odd)
  );

  ryuv_line_ram u_line_ram (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (mem_rd_data)
  );

  ryuv_color u_color (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  `RYUV_ASSERT_SAME(a_full_blocks_input, clk, rst_n, s1.valid && !adv, !in_tready)
  `RYUV_ASSERT_SAME(a_no_chroma_is_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[23:8] == 16'd0)
  `RYUV_ASSERT_NEXT(a_pair_phase_flips, clk, rst_n, in_tvalid && in_tready, col_odd != $past(col_odd))
  `RYUV_ASSERT_SAME(a_line_one_access, clk, rst_n, mem_req.wr_en, !mem_req.rd_en)

endmodule

`default_nettype wire
